// ===== rtl/wildcard_byte_pattern_search_defines.svh =====
// Assertion macros for the wildcard byte pattern search block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WBPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbps: check failed");

// Next-cycle implication, disabled during reset.
`define WBPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbps: check failed");

`endif

// ===== rtl/wbps_pkg.sv =====
// Package for the wildcard byte pattern search block: sizes, register codes,
// the per-cell reference type and the pattern alignment function.
// No dependencies.
package wbps_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int REG_BYTES     = 16;
    localparam int OFFSET_W      = 32;
    localparam int ADDR_W        = 64;
    localparam int LEN_W         = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int SEL_W         = $clog2(REG_BYTES);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 3'd0,
        CFG_PAT_HIGH = 3'd1,
        CFG_CARE     = 3'd2,
        CFG_LEN      = 3'd3,
        CFG_BASE     = 3'd4
    } cfg_idx_t;

    // Expected byte and care flag seen by one window cell.
    typedef struct packed {
        logic [7:0] value;
        logic       care;
    } cell_ref_t;

    // Cell k holds the byte that pattern byte (len - 1 - k) is compared with.
    function automatic cell_ref_t cell_ref(
        input logic [8*REG_BYTES-1:0] pat,
        input logic [REG_BYTES-1:0]   care,
        input logic [LEN_W-1:0]       len,
        input int                     k
    );
        cell_ref_t        r;
        int               j;
        logic [SEL_W-1:0] sel;
        j       = int'(len) - 1 - k;
        sel     = j[SEL_W-1:0];
        r.value = 8'd0;
        r.care  = 1'b0;
        if (j >= 0 && j < REG_BYTES)
        begin
            r.value = pat[8*sel +: 8];
            r.care  = care[sel];
        end
        return r;
    endfunction

endpackage

// ===== rtl/wbps_in_if.sv =====
// Input channel of the wildcard byte pattern search block.
// Uses wbps_pkg for nothing; valid/ready handshake with byte payload.
interface wbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/wbps_out_if.sv =====
// Result channel of the wildcard byte pattern search block.
// Depends on wbps_pkg for the address width.
interface wbps_out_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [wbps_pkg::ADDR_W-1:0] match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink   (input valid, input found, input match_address, output ready);
endinterface

// ===== rtl/wildcard_byte_pattern_search.sv =====
// Wildcard byte pattern search, top level.
// Bytes register into the window and stage 1; results then into the output register.
// Throughput: one byte per cycle while the output side takes results; the window
// chain shifts one byte per cycle and the compare runs on the registered window.
// Reset (rst_n low, asynchronous) zeroes all configuration registers, empties the
// pipeline and starts a fresh scan; there is no clearing pass.
`include "wildcard_byte_pattern_search_defines.svh"

module wildcard_byte_pattern_search (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data,
    wbps_in_if.sink                             in_ch,
    wbps_out_if.source                          out_ch
);

    localparam int PB = wbps_pkg::PATTERN_BYTES;
    localparam int OW = wbps_pkg::OFFSET_W;
    localparam int AW = wbps_pkg::ADDR_W;
    localparam int RB = wbps_pkg::REG_BYTES;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [8*RB/2-1:0]            pat_low_reg;
    logic [8*RB/2-1:0]            pat_high_reg;
    logic [RB-1:0]                care_reg;
    logic [wbps_pkg::LEN_W-1:0]   len_reg;
    logic [AW-1:0]                base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= '0;
            len_reg      <= '0;
            base_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wbps_pkg::CFG_PAT_LOW:  pat_low_reg  <= cfg_data[8*RB/2-1:0];
                wbps_pkg::CFG_PAT_HIGH: pat_high_reg <= cfg_data[8*RB/2-1:0];
                wbps_pkg::CFG_CARE:     care_reg     <= cfg_data[RB-1:0];
                wbps_pkg::CFG_LEN:      len_reg      <= cfg_data[wbps_pkg::LEN_W-1:0];
                wbps_pkg::CFG_BASE:     base_reg     <= cfg_data[AW-1:0];
                default:                ;  // unknown index: drop the write
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake and pipeline control
    // ---------------------------------------------------------------
    logic           s1_valid_reg, s1_valid_next;
    logic           s1_last_reg,  s1_last_next;
    logic           s1_ok_reg,    s1_ok_next;
    logic [OW-1:0]  s1_start_reg, s1_start_next;
    logic           restart_reg,  restart_next;
    logic [OW-1:0]  offset_reg,   offset_next;
    logic           done_reg,     done_next;
    logic           out_valid_reg, out_valid_next;
    logic           found_reg,    found_next;
    logic [AW-1:0]  addr_reg,     addr_next;

    logic           in_xfer;
    logic           out_free;
    logic           s1_match;
    logic           s1_emit;
    logic           s1_adv;
    logic [OW-1:0]  cur_offset;
    logic [OW-1:0]  len_ext;

    // Window cells, entry 0 newest.
    logic [7:0]               cell_byte [PB];
    logic [PB-1:0]            cell_hit;
    wbps_pkg::cell_ref_t      cell_refs [PB];

    // Result is produced when the scan is still open and either matches
    // or ends here; matched scans drop the rest of their bytes silently.
    assign s1_match = s1_ok_reg && (&cell_hit);
    assign s1_emit  = !done_reg && (s1_match || s1_last_reg);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign s1_adv   = s1_valid_reg && (!s1_emit || out_free);

    assign in_ch.ready = !s1_valid_reg || s1_adv;
    assign in_xfer     = in_ch.valid && in_ch.ready;

    // ---------------------------------------------------------------
    // Cell chain
    // ---------------------------------------------------------------
    genvar k;
    generate
        for (k = 0; k < PB; k++)
        begin : g_cell
            assign cell_refs[k] = wbps_pkg::cell_ref({pat_high_reg, pat_low_reg},
                                                     care_reg, len_reg, k);
            if (k == 0)
            begin : g_head
                wbps_cell u_cell (
                    .clk      (clk),
                    .shift    (in_xfer),
                    .clear    (1'b0),
                    .byte_in  (in_ch.data_byte),
                    .ref_in   (cell_refs[k]),
                    .byte_out (cell_byte[k]),
                    .hit      (cell_hit[k])
                );
            end
            else
            begin : g_body
                // First byte of a new scan shifts into an all-zero window.
                wbps_cell u_cell (
                    .clk      (clk),
                    .shift    (in_xfer),
                    .clear    (restart_reg),
                    .byte_in  (cell_byte[k-1]),
                    .ref_in   (cell_refs[k]),
                    .byte_out (cell_byte[k]),
                    .hit      (cell_hit[k])
                );
            end
        end
    endgenerate

    // ---------------------------------------------------------------
    // Stage 1: offset tracking and match start position
    // ---------------------------------------------------------------
    assign cur_offset = restart_reg ? '0 : offset_reg;
    assign len_ext    = OW'(len_reg);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_last_next  = s1_last_reg;
        s1_ok_next    = s1_ok_reg;
        s1_start_next = s1_start_reg;
        restart_next  = restart_reg;
        offset_next   = offset_reg;
        if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
            s1_last_next  = in_ch.last_byte;
            // Pattern fits in the window and enough bytes have arrived.
            s1_ok_next    = (len_reg != '0) && (len_ext <= OW'(PB))
                            && (cur_offset >= len_ext - OW'(1));
            s1_start_next = cur_offset - (len_ext - OW'(1));
            restart_next  = in_ch.last_byte;
            // Saturate the offset at its maximum.
            offset_next   = (&cur_offset) ? cur_offset : cur_offset + OW'(1);
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: match decision and output register
    // ---------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        addr_next      = addr_reg;
        done_next      = done_reg;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            if (s1_emit)
            begin
                out_valid_next = 1'b1;
                found_next     = s1_match;
                addr_next      = s1_match ? base_reg + AW'(s1_start_reg) : '0;
            end
            // Hold the done flag until the scan's last byte passes.
            if (done_reg || s1_match)
            begin
                done_next = !s1_last_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            restart_reg   <= 1'b1;
            offset_reg    <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            restart_reg   <= restart_next;
            offset_reg    <= offset_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg  <= s1_last_next;
        s1_ok_reg    <= s1_ok_next;
        s1_start_reg <= s1_start_next;
        found_reg    <= found_next;
        addr_reg     <= addr_next;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.found         = found_reg;
    assign out_ch.match_address = addr_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `WBPS_ASSERT_NOW(a_nomatch_zero_addr, out_valid_reg && !found_reg, addr_reg == '0)
    `WBPS_ASSERT_NEXT(a_last_restarts, in_xfer && in_ch.last_byte, restart_reg && offset_reg == '0 || restart_reg)
    `WBPS_ASSERT_NEXT(a_match_closes_scan, s1_adv && s1_emit && s1_match && !s1_last_reg, done_reg)
    `WBPS_ASSERT_NOW(a_done_no_emit, done_reg && s1_valid_reg, !s1_emit)

endmodule

// ===== rtl/wbps_cell.sv =====
// One window cell: holds one byte, passes it to its neighbor on shift,
// and compares it with its aligned pattern byte. Depends on wbps_pkg.
module wbps_cell (
    input  logic                clk,
    input  logic                shift,
    input  logic                clear,
    input  logic [7:0]          byte_in,
    input  wbps_pkg::cell_ref_t ref_in,
    output logic [7:0]          byte_out,
    output logic                hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (shift)
        begin
            byte_next = clear ? 8'd0 : byte_in;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;
    assign hit      = !ref_in.care || (byte_reg == ref_in.value);

endmodule
